// ===== src/rsvt_pkg.sv =====
`default_nettype none
package rsvt_pkg;

    // block geometry
    localparam int SINE_LEN   = 1024;
    localparam int POLY       = 32;
    localparam int KLEN       = 8;
    localparam int DEPTH      = 512;
    localparam int SIN_BITS   = $clog2(SINE_LEN);
    localparam int DEPTH_BITS = $clog2(DEPTH);
    localparam int KIDX_W     = $clog2(KLEN);
    localparam int PH_W       = $clog2(POLY);
    localparam int KHALF      = KLEN / 2;
    localparam int SINE_QTR   = SINE_LEN / 4;
    localparam int SINQ_N     = SINE_LEN / 4 + 1;
    localparam int SINQ_W     = 31;
    localparam int COEF_N     = POLY * KLEN;
    localparam int COEF_W     = 32;
    localparam int COEF_IDX_W = $clog2(COEF_N);
    localparam int ADDR_W     = 5;
    localparam longint unsigned SIN_USTEP = 64'd4294967296 / SINE_LEN;

    // fixed-point constants
    localparam longint ONE24 = 64'sd16777216;
    localparam longint ONE30 = 64'sd1073741824;
    localparam longint unsigned PI_Q30     = 64'd3373259426;
    localparam longint unsigned HALFPI_Q30 = 64'd1686629713;
    localparam logic signed [11:0] SMOOTH_K = 12'sd1049;
    localparam logic [15:0] MIX_ONE  = 16'd32768;
    localparam logic [15:0] MIX_STEP = 16'd7;

    // register map
    localparam logic [2:0] REG_RATE_STEP     = 3'd0;
    localparam logic [2:0] REG_TREMOLO_DEPTH = 3'd1;
    localparam logic [2:0] REG_VIBRATO_DEPTH = 3'd2;
    localparam logic [2:0] REG_PHASE_OFFSET  = 3'd3;
    localparam logic [2:0] REG_EFFECT_ON     = 3'd4;

    typedef struct packed {
        logic signed [23:0] left_in;
        logic signed [23:0] right_in;
    } t_in_word;

    typedef struct packed {
        logic signed [23:0] left_out;
        logic signed [23:0] right_out;
    } t_out_word;

    typedef struct packed {
        logic [23:0] rate_step;
        logic [15:0] tremolo_depth;
        logic [15:0] vibrato_depth;
        logic [15:0] phase_offset;
        logic        effect_on;
    } t_cfg;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SMOOTH, S_DECIDE, S_LFO0, S_LFO1, S_LFO2,
        S_MOD, S_TAP, S_WG, S_MIX, S_FINISH
    } t_state;

    typedef struct packed {
        logic                  clear;
        logic [DEPTH_BITS-1:0] clear_addr;
        logic                  load;
        logic                  smooth;
        logic                  mem_write;
        logic                  ch;
        logic                  lfo_t0;
        logic                  lfo_t1;
        logic                  lfo_val;
        logic                  modulate;
        logic                  tap_issue;
        logic [KIDX_W-1:0]     tap_idx;
        logic                  tap_acc;
        logic                  wg;
        logic                  mix;
        logic                  finish;
    } t_cmd;

    typedef struct packed {
        logic mix_zero;
        logic out_free;
    } t_status;

    // shift and subtract quotient, used only while building the tables
    function automatic longint unsigned udiv(input longint unsigned n,
                                             input longint unsigned d);
        longint unsigned q, rm;
        q = '0;
        rm = '0;
        for (int b = 63; b >= 0; b--) begin
            rm = {rm[62:0], n[b]};
            if (rm >= d) begin
                rm = rm - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // taylor divisors (2k)(2k+1)
    function automatic longint unsigned taylor_div(input int k);
        case (k)
            1:       return 64'd6;
            2:       return 64'd20;
            3:       return 64'd42;
            4:       return 64'd72;
            5:       return 64'd110;
            6:       return 64'd156;
            default: return 64'd210;
        endcase
    endfunction

    // sine of u turns (q0.32), result q30
    function automatic longint sin_cycles(input logic [31:0] u);
        logic [1:0] quad;
        longint unsigned r, x, x2, term;
        longint sm;
        quad = u[31:30];
        r = {34'd0, u[29:0]};
        if (quad[0]) begin
            r = (64'd1 << 30) - r;
        end
        x = (r * HALFPI_Q30) >> 30;
        x2 = (x * x) >> 30;
        sm = longint'(x);
        term = x;
        for (int k = 1; k <= 7; k++) begin
            term = udiv((term * x2) >> 30, taylor_div(k));
            if (k % 2 == 1) begin
                sm = sm - longint'(term);
            end else begin
                sm = sm + longint'(term);
            end
        end
        if (sm < 0) sm = 0;
        if (sm > ONE30) sm = ONE30;
        return (quad[1]) ? -sm : sm;
    endfunction

    // sinc(n/d) in q30
    function automatic longint sinc_q30(input longint n, input longint d);
        longint unsigned a, m, pn, mag, d2, sa;
        longint s;
        logic [31:0] uarg;
        if (n == 0) return ONE30;
        a = (n < 0) ? longint'(-n) : longint'(n);
        d2 = longint'(2 * d);
        m = a - udiv(a, d2) * d2;
        uarg = 32'(udiv(m << 32, d2));
        s = sin_cycles(uarg);
        pn = udiv(PI_Q30 * a, longint'(d));
        sa = (s < 0) ? longint'(-s) : longint'(s);
        mag = udiv(sa << 30, pn);
        return (s < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    // quarter-wave sine magnitudes, q30
    function automatic logic [SINQ_N*SINQ_W-1:0] build_sinq();
        logic [SINQ_N*SINQ_W-1:0] res;
        longint v;
        logic [31:0] u;
        res = '0;
        for (int k = 0; k < SINQ_N; k++) begin
            u = 32'(longint'(k) * longint'(SIN_USTEP));
            v = sin_cycles(u);
            res[k*SINQ_W +: SINQ_W] = v[SINQ_W-1:0];
        end
        return res;
    endfunction

    // polyphase windowed-sinc kernel, q30
    function automatic logic [COEF_N*COEF_W-1:0] build_coef();
        logic [COEF_N*COEF_W-1:0] res;
        longint pm, n1, n2, v, c;
        res = '0;
        pm = POLY - 1;
        for (int i = 0; i < POLY; i++) begin
            for (int x = 0; x < KLEN; x++) begin
                n1 = longint'(x - KHALF + 1) * pm - i;
                n2 = 2 * (longint'(x + 1) * pm - i) - longint'(KLEN) * pm;
                v = sinc_q30(n1, pm) * sinc_q30(n2, longint'(KLEN) * pm);
                c = (v + (64'sd1 <<< 29)) >>> 30;
                res[(i*KLEN+x)*COEF_W +: COEF_W] = c[COEF_W-1:0];
            end
        end
        return res;
    endfunction

    localparam logic [SINQ_N*SINQ_W-1:0] SINQ_TAB = build_sinq();
    localparam logic [COEF_N*COEF_W-1:0] COEF_TAB = build_coef();

    // full sine table entry, (sin+1)/2 in q0.24
    function automatic logic [24:0] sine_entry(input logic [SIN_BITS-1:0] idx);
        logic [SIN_BITS-3:0] j;
        logic [SIN_BITS-2:0] k;
        logic [31:0] s;
        logic [31:0] sm;
        j = idx[SIN_BITS-3:0];
        k = idx[SIN_BITS-2] ? (SIN_BITS-1)'(SINE_QTR) - {1'b0, j} : {1'b0, j};
        s = {1'b0, SINQ_TAB[k*SINQ_W +: SINQ_W]};
        sm = idx[SIN_BITS-1] ? 32'(ONE30) - s + 32'd64 : 32'(ONE30) + s + 32'd64;
        return sm[31:7];
    endfunction

    function automatic logic signed [COEF_W-1:0] coef_at(input logic [COEF_IDX_W-1:0] idx);
        return $signed(COEF_TAB[idx*COEF_W +: COEF_W]);
    endfunction

endpackage
`default_nettype wire

// ===== src/rsvt_ctrl.sv =====
`default_nettype none
module rsvt_ctrl import rsvt_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state                r_state, n_state;
    logic                  r_ch, n_ch;
    logic [KIDX_W:0]       r_k, n_k;
    logic [DEPTH_BITS-1:0] r_clr, n_clr;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ch    <= 1'b0;
            r_k     <= '0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
            r_k     <= n_k;
            r_clr   <= n_clr;
        end
    end

    // sequencing and commands
    always_comb begin
        n_state = r_state;
        n_ch    = r_ch;
        n_k     = r_k;
        n_clr   = r_clr;
        o_cmd   = '0;
        o_cmd.ch         = r_ch;
        o_cmd.tap_idx    = r_k[KIDX_W-1:0];
        o_cmd.clear_addr = r_clr;
        o_in_stall = (r_state != S_IDLE);
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_clr = r_clr + 1'b1;
                if (r_clr == DEPTH_BITS'(DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_SMOOTH;
                end
            end
            S_SMOOTH: begin
                o_cmd.smooth = 1'b1;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_status.mix_zero) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.mem_write = 1'b1;
                    n_ch = 1'b0;
                    n_state = S_LFO0;
                end
            end
            S_LFO0: begin
                o_cmd.lfo_t0 = 1'b1;
                n_state = S_LFO1;
            end
            S_LFO1: begin
                o_cmd.lfo_t1 = 1'b1;
                n_state = S_LFO2;
            end
            S_LFO2: begin
                o_cmd.lfo_val = 1'b1;
                n_state = S_MOD;
            end
            S_MOD: begin
                o_cmd.modulate = 1'b1;
                n_k = '0;
                n_state = S_TAP;
            end
            S_TAP: begin
                o_cmd.tap_issue = (r_k < (KIDX_W+1)'(KLEN));
                o_cmd.tap_acc   = (r_k != '0);
                n_k = r_k + 1'b1;
                if (r_k == (KIDX_W+1)'(KLEN)) n_state = S_WG;
            end
            S_WG: begin
                o_cmd.wg = 1'b1;
                n_state = S_MIX;
            end
            S_MIX: begin
                o_cmd.mix = 1'b1;
                if (r_ch) begin
                    n_state = S_FINISH;
                end else begin
                    n_ch = 1'b1;
                    n_state = S_LFO0;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== src/rsvt_dp.sv =====
`default_nettype none
module rsvt_dp import rsvt_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    input  wire t_cmd     i_cmd,
    output t_status       o_status,
    input  wire t_in_word i_in_data,
    output t_out_word     o_out_data,
    output logic          o_out_valid,
    input  wire logic     i_out_stall
);

    function automatic logic [31:0] smooth(input logic [31:0] s, input logic [31:0] t);
        logic signed [32:0] diff;
        logic signed [44:0] prod;
        logic signed [44:0] adj;
        diff = $signed({1'b0, t}) - $signed({1'b0, s});
        prod = diff * SMOOTH_K;
        adj  = (prod + 45'sd524288) >>> 20;
        return s + adj[31:0];
    endfunction

    // delay lines
    logic signed [23:0] mem_l [0:DEPTH-1];
    logic signed [23:0] mem_r [0:DEPTH-1];

    logic signed [23:0] r_lin, r_rin, r_lo, r_ro;
    logic [31:0] r_rate_s, r_trem_s, r_vib_s, r_phase_s;
    logic [15:0] r_mix;
    logic [DEPTH_BITS-1:0] r_wi;
    logic [23:0] r_lfo;
    logic [24:0] r_t0, r_t1, r_val, r_g;
    logic [32:0] r_dm;
    logic signed [34:0] r_c;
    logic signed [23:0] r_rd_l, r_rd_r;
    logic signed [63:0] r_acc;
    logic signed [35:0] r_wg;
    t_out_word r_out;
    logic r_out_valid;

    // combinational datapath values
    logic [23:0] ch_phase;
    logic [SIN_BITS-1:0] sidx;
    logic [24:0] sent;
    logic [23:0] lf_f;
    logic signed [25:0] lf_diff;
    logic signed [50:0] lf_prod;
    logic signed [26:0] lf_v;
    logic [24:0] lf_val;
    logic [24:0] om;
    logic [56:0] dm_full, tp_full;
    logic [23+PH_W:0] cpos;
    logic [PH_W-1:0] ic;
    logic [23:0] fc;
    logic [COEF_IDX_W-1:0] cidx0, cidx1;
    logic signed [58:0] cterm;
    logic signed [58:0] cround;
    logic [DEPTH_BITS-1:0] rd_addr;
    logic signed [23:0] rd_sel;
    logic signed [63:0] acc_rnd;
    logic signed [59:0] wg_prod;
    logic signed [59:0] wg_rnd;
    logic signed [23:0] dry;
    logic signed [53:0] mix_sum;
    logic signed [53:0] mix_rnd;
    logic signed [23:0] mix_sat;
    logic [DEPTH_BITS-1:0] wr_addr;
    logic signed [23:0] wr_l, wr_r;

    // lfo and modulation arithmetic
    always_comb begin
        ch_phase = i_cmd.ch ? r_lfo + r_phase_s[31:8] : r_lfo;
        sidx = ch_phase[23 -: SIN_BITS] + (i_cmd.lfo_t1 ? SIN_BITS'(1) : SIN_BITS'(0));
        sent = sine_entry(sidx);
        lf_f = {ch_phase[23-SIN_BITS:0], SIN_BITS'(0)};
        lf_diff = $signed({1'b0, r_t1}) - $signed({1'b0, r_t0});
        lf_prod = lf_diff * $signed({1'b0, lf_f});
        lf_v = $signed({2'b00, r_t0}) + 27'((lf_prod + 51'sd8388608) >>> 24);
        if (lf_v < 0) begin
            lf_val = '0;
        end else if (lf_v > 27'sd16777216) begin
            lf_val = 25'd16777216;
        end else begin
            lf_val = lf_v[24:0];
        end
        om = 25'd16777216 - r_val;
        dm_full = {32'd0, om} * {25'd0, r_vib_s};
        tp_full = {32'd0, om} * {25'd0, r_trem_s};
    end

    // tap addressing and coefficient interpolation
    always_comb begin
        cpos = r_dm[23:0] * (24+PH_W)'(POLY - 1);
        ic = cpos[23+PH_W:24];
        if (ic > PH_W'(POLY - 2)) ic = PH_W'(POLY - 2);
        fc = cpos[23:0];
        cidx0 = COEF_IDX_W'(ic) * COEF_IDX_W'(KLEN) + COEF_IDX_W'(i_cmd.tap_idx);
        cidx1 = cidx0 + COEF_IDX_W'(KLEN);
        cterm = coef_at(cidx0) * $signed({1'b0, 25'd16777216 - {1'b0, fc}})
              + coef_at(cidx1) * $signed({2'b00, fc});
        cround = (cterm + 59'sd8388608) >>> 24;
        rd_addr = r_wi - DEPTH_BITS'(r_dm[31:24]) - DEPTH_BITS'(i_cmd.tap_idx);
        rd_sel = i_cmd.ch ? r_rd_r : r_rd_l;
    end

    // tremolo gain, dry/wet mix and delay line write selection
    always_comb begin
        acc_rnd = (r_acc + 64'sd536870912) >>> 30;
        wg_prod = $signed(acc_rnd[33:0]) * $signed({1'b0, r_g});
        wg_rnd = (wg_prod + 60'sd8388608) >>> 24;
        dry = i_cmd.ch ? r_rin : r_lin;
        mix_sum = r_wg * $signed({1'b0, r_mix})
                + dry * $signed({1'b0, MIX_ONE - r_mix});
        mix_rnd = (mix_sum + 54'sd16384) >>> 15;
        if (mix_rnd > 54'sd8388607) begin
            mix_sat = 24'sd8388607;
        end else if (mix_rnd < -54'sd8388608) begin
            mix_sat = -24'sd8388608;
        end else begin
            mix_sat = mix_rnd[23:0];
        end
        wr_addr = i_cmd.clear ? i_cmd.clear_addr : r_wi;
        wr_l = i_cmd.clear ? 24'sd0 : r_lin;
        wr_r = i_cmd.clear ? 24'sd0 : r_rin;
    end

    // delay line ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear || i_cmd.mem_write) begin
            mem_l[wr_addr] <= wr_l;
            mem_r[wr_addr] <= wr_r;
        end
        if (i_cmd.tap_issue) begin
            r_rd_l <= mem_l[rd_addr];
            r_rd_r <= mem_r[rd_addr];
        end
    end

    // payload pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lin <= i_in_data.left_in;
            r_rin <= i_in_data.right_in;
        end
        if (i_cmd.lfo_t0) r_t0 <= sent;
        if (i_cmd.lfo_t1) r_t1 <= sent;
        if (i_cmd.lfo_val) r_val <= lf_val;
        if (i_cmd.modulate) begin
            r_dm <= dm_full[56:24];
            r_g  <= 25'd16777216 - tp_full[56:32];
        end
        if (i_cmd.tap_issue) r_c <= cround[34:0];
        if (i_cmd.modulate) begin
            r_acc <= '0;
        end else if (i_cmd.tap_acc) begin
            r_acc <= r_acc + rd_sel * r_c;
        end
        if (i_cmd.wg) r_wg <= wg_rnd[35:0];
        if (i_cmd.mix) begin
            if (i_cmd.ch) r_ro <= mix_sat;
            else r_lo <= mix_sat;
        end
        if (i_cmd.finish) begin
            if (r_mix == '0) begin
                r_out.left_out  <= r_lin;
                r_out.right_out <= r_rin;
            end else begin
                r_out.left_out  <= r_lo;
                r_out.right_out <= r_ro;
            end
        end
    end

    // smoothers, mix, write pointer, lfo phase, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_s    <= '0;
            r_trem_s    <= '0;
            r_vib_s     <= '0;
            r_phase_s   <= '0;
            r_mix       <= '0;
            r_wi        <= '0;
            r_lfo       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.smooth) begin
                r_rate_s  <= smooth(r_rate_s, {i_cfg.rate_step, 8'd0});
                r_trem_s  <= smooth(r_trem_s, {i_cfg.tremolo_depth, 16'd0});
                r_vib_s   <= smooth(r_vib_s, {i_cfg.vibrato_depth, 16'd0});
                r_phase_s <= smooth(r_phase_s, {i_cfg.phase_offset, 16'd0});
                if (i_cfg.effect_on) begin
                    r_mix <= (r_mix + MIX_STEP > MIX_ONE) ? MIX_ONE : r_mix + MIX_STEP;
                end else if (r_mix != '0) begin
                    r_mix <= (r_mix < MIX_STEP) ? 16'd0 : r_mix - MIX_STEP;
                end
            end
            if (i_cmd.finish) begin
                r_wi        <= r_wi + 1'b1;
                r_lfo       <= r_lfo + r_rate_s[31:8];
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.mix_zero = (r_mix == '0);
    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_data  = r_out;
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// ===== src/rotary_speaker_vibrato_tremolo.sv =====
`default_nettype none
// rotary speaker effect: vibrato through a modulated delay plus tremolo
// input channel: one stereo word (left_in, right_in, q1.23) on i_in_data,
// taken when i_in_valid is high and o_in_stall is low
// output channel: one stereo word on o_out_data, taken when o_out_valid
// is high and i_out_stall is low; the word holds while stalled
// settings arrive over the apb port (rate_step, tremolo_depth,
// vibrato_depth, phase_offset, effect_on at byte addresses 0..16)
// the result of a word follows the smooth and decide steps when the mix is
// fully dry, and otherwise also two passes (left, right) over the 8-tap
// kernel through a single multiply-accumulate and delay line read port;
// one word is in work at a time, so no new word is taken until the result
// of the last has been handed to the output register
// a new word is taken while the previous result still waits to leave;
// the next result is parked until the receiver takes the previous one
// reset: all settings and smoothers go to zero and both delay lines are
// cleared, one entry per cycle, before the first word is taken
module rotary_speaker_vibrato_tremolo import rsvt_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire t_in_word          i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_out_word              o_out_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    t_cfg    r_cfg;
    t_cmd    cmd;
    t_status status;
    logic [2:0] reg_idx;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign pready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_RATE_STEP:     r_cfg.rate_step     <= pwdata[23:0];
                REG_TREMOLO_DEPTH: r_cfg.tremolo_depth <= pwdata[15:0];
                REG_VIBRATO_DEPTH: r_cfg.vibrato_depth <= pwdata[15:0];
                REG_PHASE_OFFSET:  r_cfg.phase_offset  <= pwdata[15:0];
                REG_EFFECT_ON:     r_cfg.effect_on     <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_idx)
            REG_RATE_STEP:     prdata = {8'd0, r_cfg.rate_step};
            REG_TREMOLO_DEPTH: prdata = {16'd0, r_cfg.tremolo_depth};
            REG_VIBRATO_DEPTH: prdata = {16'd0, r_cfg.vibrato_depth};
            REG_PHASE_OFFSET:  prdata = {16'd0, r_cfg.phase_offset};
            REG_EFFECT_ON:     prdata = {31'd0, r_cfg.effect_on};
            default:           prdata = 32'd0;
        endcase
    end

    rsvt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rsvt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_in_data),
        .o_out_data  (o_out_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall)
    );

endmodule
`default_nettype wire

// ===== verif/tb_rotary_speaker_vibrato_tremolo.sv =====
`timescale 1ns / 1ps

module tb_rotary_speaker_vibrato_tremolo;

    localparam int  SINE_N     = 1024;
    localparam int  PHASES     = 32;
    localparam int  TAPS       = 8;
    localparam int  LINE_LEN   = 512;
    localparam longint Q24_ONE = 64'sd16777216;
    localparam longint Q30_ONE = 64'sd1073741824;
    localparam longint SMOOTH_GAIN = 64'sd1049;
    localparam longint FULL_WET = 64'sd32768;
    localparam longint WET_STEP = 64'sd7;
    localparam int  IDLE_LIMIT = 5000;
    localparam int  SETTLE_CYCLES = 40;
    localparam logic [2:0] REG_UNMAPPED = 3'd5;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    rsvt_pkg::t_in_word    i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    rsvt_pkg::t_out_word   o_out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [rsvt_pkg::ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    rotary_speaker_vibrato_tremolo u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // predictor tables
    longint sine_lut [SINE_N];
    longint kernel [PHASES][TAPS];

    // predictor settings and state
    logic [23:0] set_rate;
    logic [15:0] set_trem;
    logic [15:0] set_vib;
    logic [15:0] set_phase;
    logic        set_on;
    longint      line_l [LINE_LEN];
    longint      line_r [LINE_LEN];
    int          wr_ptr;
    logic [23:0] lfo_ph;
    logic [31:0] rate_s, trem_s, vib_s, phase_s;
    longint      wet_lvl;

    rsvt_pkg::t_out_word pending_words [$];
    int  fail_count;
    int  idle_cycles;
    bit  in_take, out_take, cfg_take;

    // round to nearest, ties upward
    function automatic longint rnd_shr(input longint v, input int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    // sine of u turns (q0.32) as q30, taylor series
    function automatic longint sine_q30(input logic [31:0] u);
        longint unsigned r, x, x2, term;
        longint acc;
        r = {34'd0, u[29:0]};
        if (u[30]) begin
            r = (64'd1 << 30) - r;
        end
        x = (r * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        acc = longint'(x);
        term = x;
        for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / 64'(2 * k * (2 * k + 1));
            if (k % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) acc = 0;
        if (acc > Q30_ONE) acc = Q30_ONE;
        return u[31] ? -acc : acc;
    endfunction

    // sinc(n/d) as q30
    function automatic longint sinc_val(input longint n, input longint d);
        longint unsigned a, m, pn, sa, mag, dd;
        longint s;
        if (n == 0) return Q30_ONE;
        a = unsigned'(n < 0 ? -n : n);
        dd = unsigned'(d);
        m = a % (2 * dd);
        s = sine_q30(32'((m << 32) / (2 * dd)));
        pn = (64'd3373259426 * a) / dd;
        sa = unsigned'(s < 0 ? -s : s);
        mag = (sa << 30) / pn;
        return (s < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic void build_luts();
        longint pm, n1, n2;
        pm = PHASES - 1;
        for (int i = 0; i < SINE_N; i++) begin
            sine_lut[i] = (Q30_ONE + sine_q30(32'(longint'(i) << 22)) + 64) >>> 7;
        end
        for (int p = 0; p < PHASES; p++) begin
            for (int x = 0; x < TAPS; x++) begin
                n1 = longint'(x - TAPS / 2 + 1) * pm - p;
                n2 = 2 * (longint'(x + 1) * pm - p) - longint'(TAPS) * pm;
                kernel[p][x] = rnd_shr(sinc_val(n1, pm) * sinc_val(n2, TAPS * pm), 30);
            end
        end
    endfunction

    function automatic logic [31:0] smooth_step(input logic [31:0] s, input logic [31:0] t);
        longint diff;
        diff = longint'({32'd0, t}) - longint'({32'd0, s});
        return 32'(longint'({32'd0, s}) + rnd_shr(diff * SMOOTH_GAIN, 20));
    endfunction

    // interpolated lfo, q0.24 in [0, 1]
    function automatic longint lfo_at(input logic [23:0] ph);
        longint pos, f, t0, t1, v;
        int idx;
        pos = longint'({40'd0, ph}) * SINE_N;
        idx = int'((pos >>> 24) % SINE_N);
        f = pos & 64'hFFFFFF;
        t0 = sine_lut[idx];
        t1 = sine_lut[(idx + 1) % SINE_N];
        v = t0 + rnd_shr((t1 - t0) * f, 24);
        if (v < 0) v = 0;
        if (v > Q24_ONE) v = Q24_ONE;
        return v;
    endfunction

    // one channel: fractional delay read, tremolo, wet/dry crossfade
    function automatic longint channel_out(input bit right, input logic [23:0] ph,
                                           input longint dry);
        longint unsigned dm, cpos;
        longint val, fc, c, acc, w, g, wg, o, samp;
        int imod, ic, idx;
        val = lfo_at(ph);
        dm = (unsigned'(Q24_ONE - val) * {32'd0, vib_s}) >> 24;
        imod = int'(dm >> 24);
        cpos = (dm & 64'hFFFFFF) * (PHASES - 1);
        ic = int'(cpos >> 24);
        fc = longint'(cpos & 64'hFFFFFF);
        if (ic > PHASES - 2) ic = PHASES - 2;
        acc = 0;
        for (int x = 0; x < TAPS; x++) begin
            c = rnd_shr(kernel[ic][x] * (Q24_ONE - fc) + kernel[ic + 1][x] * fc, 24);
            idx = (wr_ptr - imod - x) & (LINE_LEN - 1);
            samp = right ? line_r[idx] : line_l[idx];
            acc += samp * c;
        end
        w = rnd_shr(acc, 30);
        g = Q24_ONE - longint'(({32'd0, trem_s} * unsigned'(Q24_ONE - val)) >> 32);
        wg = rnd_shr(w * g, 24);
        o = rnd_shr(wg * wet_lvl + dry * (FULL_WET - wet_lvl), 15);
        if (o > 8388607) o = 8388607;
        if (o < -8388608) o = -8388608;
        return o;
    endfunction

    function automatic rsvt_pkg::t_out_word rotary_predict(input rsvt_pkg::t_in_word w);
        rsvt_pkg::t_out_word r;
        longint lin, rin;
        lin = longint'(w.left_in);
        rin = longint'(w.right_in);
        rate_s  = smooth_step(rate_s,  {set_rate, 8'd0});
        trem_s  = smooth_step(trem_s,  {set_trem, 16'd0});
        phase_s = smooth_step(phase_s, {set_phase, 16'd0});
        vib_s   = smooth_step(vib_s,   {set_vib, 16'd0});
        if (set_on) begin
            wet_lvl += WET_STEP;
            if (wet_lvl > FULL_WET) wet_lvl = FULL_WET;
        end else if (wet_lvl > 0) begin
            wet_lvl -= WET_STEP;
            if (wet_lvl < 0) wet_lvl = 0;
        end
        if (wet_lvl > 0) begin
            line_l[wr_ptr] = lin;
            r.left_out = 24'(channel_out(1'b0, lfo_ph, lin));
            line_r[wr_ptr] = rin;
            r.right_out = 24'(channel_out(1'b1, lfo_ph + phase_s[31:8], rin));
        end else begin
            r.left_out = w.left_in;
            r.right_out = w.right_in;
        end
        wr_ptr = (wr_ptr + 1) % LINE_LEN;
        lfo_ph = lfo_ph + rate_s[31:8];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // result check against the oldest expected word
    always @(posedge i_clk) begin
        out_take <= i_rst_n && o_out_valid && !i_out_stall;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_words.size() == 0) begin
                $display("unexpected word %h at %0t", o_out_data, $realtime);
                fail_count++;
            end else begin
                if (o_out_data.left_out !== pending_words[0].left_out)
                    report_mismatch("left_out", o_out_data.left_out,
                                    pending_words[0].left_out);
                if (o_out_data.right_out !== pending_words[0].right_out)
                    report_mismatch("right_out", o_out_data.right_out,
                                    pending_words[0].right_out);
                void'(pending_words.pop_front());
            end
        end
    end

    // receiver stall pattern: none, random, or periodic, switching now and then
    int stall_mode;
    int stall_left;
    int stall_tick;
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(1, 80);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 2) == 0);
            default: i_out_stall <= (stall_tick % 7) < 3;
        endcase
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (in_take || out_take || cfg_take) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // drive one input word and wait until it is taken
    task automatic send_word(input rsvt_pkg::t_in_word w, input bit typed,
                             input rsvt_pkg::t_out_word want);
        rsvt_pkg::t_out_word pred;
        @(negedge i_clk);
        in_take = 1'b0;
        i_in_valid = 1'b1;
        i_in_data = w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        in_take = 1'b1;
        pred = rotary_predict(w);
        pending_words.push_back(typed ? want : pred);
    endtask

    task automatic drop_valid(input int cycles);
        for (int i = 0; i < cycles; i++) begin
            @(negedge i_clk);
            in_take = 1'b0;
            i_in_valid = 1'b0;
        end
    endtask

    // wait for the block to go quiet
    task automatic drain();
        drop_valid(1);
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = rsvt_pkg::ADDR_W'({idx, 2'b00});
        pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        cfg_take = 1'b1;
        case (idx)
            rsvt_pkg::REG_RATE_STEP:     set_rate = val[23:0];
            rsvt_pkg::REG_TREMOLO_DEPTH: set_trem = val[15:0];
            rsvt_pkg::REG_VIBRATO_DEPTH: set_vib = val[15:0];
            rsvt_pkg::REG_PHASE_OFFSET:  set_phase = val[15:0];
            rsvt_pkg::REG_EFFECT_ON:     set_on = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_take = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic cfg_all(input logic [23:0] rate, input logic [15:0] trem,
                           input logic [15:0] vib, input logic [15:0] ph, input bit on);
        cfg_write(rsvt_pkg::REG_RATE_STEP, {8'd0, rate});
        cfg_write(rsvt_pkg::REG_TREMOLO_DEPTH, {16'd0, trem});
        cfg_write(rsvt_pkg::REG_VIBRATO_DEPTH, {16'd0, vib});
        cfg_write(rsvt_pkg::REG_PHASE_OFFSET, {16'd0, ph});
        cfg_write(rsvt_pkg::REG_EFFECT_ON, {31'd0, on});
    endtask

    // random words in bursts with random gaps
    task automatic random_words(input int count);
        rsvt_pkg::t_in_word w;
        int left, burst;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && left > 0; i++) begin
                w.left_in = 24'($urandom);
                w.right_in = 24'($urandom);
                send_word(w, 1'b0, '0);
                left--;
            end
            if ($urandom_range(0, 3) != 0) drop_valid($urandom_range(1, 12));
        end
    endtask

    typedef struct {
        logic signed [23:0] l;
        logic signed [23:0] r;
        bit                 typed;
    } t_dir_row;

    localparam int DRY_ROWS = 8;
    localparam int DIR_ROWS = 20;
    t_dir_row dir_tab [DIR_ROWS] = '{
        // fully dry after reset: output equals input
        '{24'sd0, 24'sd0, 1'b1},
        '{24'sh7FFFFF, -24'sh800000, 1'b1},
        '{-24'sh800000, 24'sh7FFFFF, 1'b1},
        '{-24'sd1, 24'sd1, 1'b1},
        '{24'sh555555, 24'shAAAAAA, 1'b1},
        '{24'shAAAAAA, 24'sh555555, 1'b1},
        '{24'sh000001, -24'sh000002, 1'b1},
        '{24'sh400000, -24'sh400000, 1'b1},
        // effect on at extreme settings, long delay wrap
        '{24'sh7FFFFF, 24'sh7FFFFF, 1'b0},
        '{-24'sh800000, -24'sh800000, 1'b0},
        '{24'sh7FFFFF, -24'sh800000, 1'b0},
        '{-24'sh800000, 24'sh7FFFFF, 1'b0},
        '{24'sd0, 24'sd0, 1'b0},
        '{-24'sd1, -24'sd1, 1'b0},
        '{24'sh7FFFFF, 24'sh7FFFFF, 1'b0},
        '{24'sh7FFFFF, 24'sh7FFFFF, 1'b0},
        '{-24'sh800000, 24'sd0, 1'b0},
        '{24'sd0, -24'sh800000, 1'b0},
        '{24'sh123456, -24'sh654321, 1'b0},
        '{24'sh7FFFFF, -24'sd1, 1'b0}
    };

    initial begin
        rsvt_pkg::t_in_word w;
        rsvt_pkg::t_out_word want;
        build_luts();
        set_rate = '0;
        set_trem = '0;
        set_vib = '0;
        set_phase = '0;
        set_on = 1'b0;
        for (int i = 0; i < LINE_LEN; i++) begin
            line_l[i] = 0;
            line_r[i] = 0;
        end
        wr_ptr = 0;
        lfo_ph = '0;
        rate_s = '0;
        trem_s = '0;
        vib_s = '0;
        phase_s = '0;
        wet_lvl = 0;
        fail_count = 0;
        idle_cycles = 0;
        in_take = 1'b0;
        out_take = 1'b0;
        cfg_take = 1'b0;
        stall_mode = 0;
        stall_left = 0;
        stall_tick = 0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        for (int i = 0; i < DIR_ROWS; i++) begin
            if (i == DRY_ROWS) begin
                drain();
                cfg_all(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
                cfg_write(REG_UNMAPPED, 32'hFFFFFFFF);
            end
            w.left_in = dir_tab[i].l;
            w.right_in = dir_tab[i].r;
            want.left_out = dir_tab[i].l;
            want.right_out = dir_tab[i].r;
            send_word(w, dir_tab[i].typed, want);
        end

        // random phases across several settings
        random_words(200);
        drain();
        cfg_all(24'd0, 16'd0, 16'd0, 16'd0, 1'b1);
        random_words(100);
        drain();
        cfg_all(24'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
        random_words(200);
        // fade back to fully dry and sit on the mix floor
        drain();
        cfg_write(rsvt_pkg::REG_EFFECT_ON, 32'd0);
        random_words(700);
        drain();
        cfg_all(24'($urandom_range(0, 65535)), 16'($urandom), 16'($urandom),
                16'($urandom), 1'b1);
        random_words(100);

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
